// File: sv/lkvc_pkg.sv
// lkvc_pkg: widths, codes and payload types of the lru key/value cache
// no dependencies; used by the interfaces, the core and the top level
package lkvc_pkg;

  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;
  localparam int ENTRIES_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                    op;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
  } res_t;

endpackage

// File: sv/lkvc_ifs.sv
// lkvc_in_if / lkvc_out_if: valid/ready channels of the lru key/value cache
// depends on lkvc_pkg for field widths
interface lkvc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic signed [lkvc_pkg::KEY_W-1:0] key;
  logic signed [lkvc_pkg::VAL_W-1:0] value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface lkvc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic signed [lkvc_pkg::VAL_W-1:0] read_value;

  modport source (output valid, output found, output read_value, input ready);
  modport sink   (input valid, input found, input read_value, output ready);
endinterface

// File: sv/lru_key_value_cache_unit.sv
// lru_key_value_cache_unit: top level of the fully associative lru key/value cache
// depends on lkvc_pkg, lkvc_in_if / lkvc_out_if and lkvc_core
//
// Usage:
//   in_ch carries requests (op, key, value): op get looks up key, op put stores
//   key/value. A get gives one beat on out_ch (found, read_value, 0 on a miss);
//   a put gives none.
//   cfg_we/cfg_data write the capacity (clamped to 1..ENTRIES) and clear all
//   entries; write it only while no request is in flight.
// Timing: an accepted request is held in the input register and executes from
//   there; a get's result is registered into the output beat register.
// Throughput: one request per cycle while no get waits on out_ch; match and
//   age-rank update of all entries happen in parallel when the request executes,
//   one item in the input register at a time.
// Reset: capacity returns to 16 and the store is empty; ready comes up as soon
//   as reset is released.
// Stall: a get waits in the input register while out_ch holds an untaken beat;
//   puts keep executing. in_ch.ready is low only during reset or when the input
//   register is full and cannot execute.
module lru_key_value_cache_unit #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_data,
  lkvc_in_if.sink                    in_ch,
  lkvc_out_if.source                 out_ch
);

  lkvc_pkg::req_t req_r;
  lkvc_pkg::res_t res_r, res_c;
  logic           in_v_r, out_v_r;
  logic           out_free, exec, is_get;

  assign is_get   = (req_r.op == lkvc_pkg::OP_GET);
  assign out_free = !out_v_r || out_ch.ready;
  assign exec     = in_v_r && (!is_get || out_free);

  // no beat is taken while reset is held
  assign in_ch.ready = rst_n && (!in_v_r || exec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v_r <= 1'b1;
    end else if (exec) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_r.op    <= in_ch.op;
      req_r.key   <= in_ch.key;
      req_r.value <= in_ch.value;
    end
  end

  lkvc_core #(
    .ENTRIES (ENTRIES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .exec     (exec),
    .req      (req_r),
    .res      (res_c)
  );

  // result beat held until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (exec && is_get) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && is_get) begin
      res_r <= res_c;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.found      = res_r.found;
  assign out_ch.read_value = res_r.read_value;

endmodule

// File: sv/lkvc_core.sv
// lkvc_core: entry storage, parallel key match and age-rank update
// depends on lkvc_pkg; state changes only on exec, a capacity write or reset
module lkvc_core #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0]   cfg_data,
  input  logic                         exec,
  input  lkvc_pkg::req_t               req,
  output lkvc_pkg::res_t               res
);

  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int CW = (OW > lkvc_pkg::CAP_W) ? OW : lkvc_pkg::CAP_W;

  logic [lkvc_pkg::KEY_W-1:0] key_r  [ENTRIES];
  logic [lkvc_pkg::VAL_W-1:0] val_r  [ENTRIES];
  logic [RW-1:0]              rank_r [ENTRIES];
  logic [RW-1:0]              rank_nxt [ENTRIES];
  logic [ENTRIES-1:0]         valid_r, valid_nxt;
  logic [OW-1:0]              occ_r, occ_nxt;
  logic [lkvc_pkg::CAP_W-1:0] cap_r;

  logic [ENTRIES-1:0]         hit_vec, free_vec, victim_vec, promo_vec;
  logic                       hit, is_put, has_room, inc_all, upd, fill, seen_free;
  logic [RW-1:0]              hit_rank, oldest_rank, thresh;
  logic [lkvc_pkg::VAL_W-1:0] hit_val;
  logic [CW-1:0]              cap_ext, cap_eff;

  always_comb begin
    cap_ext = CW'(cap_r);
    cap_eff = cap_ext;
    if (cap_ext == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end
  end

  assign has_room    = CW'(occ_r) < cap_eff;
  assign oldest_rank = RW'(occ_r - OW'(1));
  assign is_put      = (req.op == lkvc_pkg::OP_PUT);

  always_comb begin
    hit_rank  = '0;
    hit_val   = '0;
    seen_free = 1'b0;
    for (int j = 0; j < ENTRIES; j++) begin
      hit_vec[j]    = valid_r[j] && (key_r[j] == req.key);
      victim_vec[j] = valid_r[j] && (rank_r[j] == oldest_rank);
      free_vec[j]   = !valid_r[j] && !seen_free;
      seen_free     = seen_free || !valid_r[j];
      hit_rank      = hit_rank | (rank_r[j] & {RW{hit_vec[j]}});
      hit_val       = hit_val | (val_r[j] & {lkvc_pkg::VAL_W{hit_vec[j]}});
    end
  end

  assign hit = |hit_vec;

  // the promoted slot: the hit entry, a free slot, or the least recent entry
  always_comb begin
    if (hit) begin
      promo_vec = hit_vec;
    end else if (has_room) begin
      promo_vec = free_vec;
    end else begin
      promo_vec = victim_vec;
    end
  end

  assign inc_all = !hit && has_room;
  assign thresh  = hit ? hit_rank : oldest_rank;
  assign upd     = exec && (hit || is_put);
  assign fill    = exec && is_put && !hit && has_room;

  always_comb begin
    valid_nxt = fill ? (valid_r | free_vec) : valid_r;
    occ_nxt   = fill ? (occ_r + OW'(1)) : occ_r;
    for (int j = 0; j < ENTRIES; j++) begin
      rank_nxt[j] = rank_r[j];
      if (upd) begin
        if (promo_vec[j]) begin
          rank_nxt[j] = '0;
        end else if (valid_r[j] && (inc_all || rank_r[j] < thresh)) begin
          rank_nxt[j] = rank_r[j] + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= lkvc_pkg::CAP_RESET;
      valid_r <= '0;
      occ_r   <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        rank_r[j] <= '0;
      end
    end else if (cfg_we) begin
      cap_r   <= cfg_data;
      valid_r <= '0;
      occ_r   <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        rank_r[j] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int j = 0; j < ENTRIES; j++) begin
        rank_r[j] <= rank_nxt[j];
      end
    end
  end

  // key and value written on any put, into the promoted slot
  always_ff @(posedge clk) begin
    for (int j = 0; j < ENTRIES; j++) begin
      if (exec && is_put && promo_vec[j]) begin
        key_r[j] <= req.key;
        val_r[j] <= req.value;
      end
    end
  end

  assign res.found      = hit;
  assign res.read_value = hit_val;

endmodule
